// ===== rtl/core/sboi_pkg.sv =====
package sboi_pkg;

  localparam int NLANES    = 3;
  localparam int NSTG      = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

  // Load enables of the pipeline stages, first stage first.
  typedef struct packed {
    logic diff;
    logic absv;
    logic pp;
    logic mag;
    logic sgn;
    logic ord;
    logic pair;
    logic fin;
    logic outr;
  } sboi_pipe_en_t;

endpackage

// ===== rtl/core/sboi_in_if.sv =====
interface sboi_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;
  logic        [COORD_BITS-2:0] half_size_x;
  logic        [COORD_BITS-2:0] half_size_y;
  logic        [COORD_BITS-2:0] half_size_z;
  logic signed [COORD_BITS-1:0] range_lo;
  logic signed [COORD_BITS-1:0] range_hi;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           half_size_x, half_size_y, half_size_z, range_lo, range_hi,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           half_size_x, half_size_y, half_size_z, range_lo, range_hi,
    output ready
  );
endinterface

// ===== rtl/core/sboi_out_if.sv =====
interface sboi_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] t_enter;
  logic signed [COORD_BITS-1:0] t_exit;

  modport source (
    output valid, hit, t_enter, t_exit,
    input  ready
  );

  modport sink (
    input  valid, hit, t_enter, t_exit,
    output ready
  );
endinterface

// ===== rtl/core/sboi_recip.sv =====
module sboi_recip #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic signed [COORD_BITS-1:0] start_pt,
  input  logic signed [COORD_BITS-1:0] end_pt,
  output logic                         busy,
  output logic        [COORD_BITS-1:0] rmag,
  output logic                         rneg
);
  localparam int DW = COORD_BITS + 1;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int QX = (QW > COORD_BITS) ? QW : COORD_BITS;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_DIFF, ST_MAG, ST_DIV, ST_SAT} state_t;

  state_t                state_r;
  logic [DW-1:0]         delta_r;
  logic [DW-1:0]         div_r;
  logic [DW-1:0]         rem_r;
  logic [DW-1:0]         mag_w;
  logic [DW-1:0]         rem_nxt;
  logic [DW:0]           trial;
  logic                  take;
  logic [QW-1:0]         quo_r;
  logic [CW-1:0]         cnt_r;
  logic [COORD_BITS-1:0] rmag_r;
  logic [COORD_BITS-1:0] cap_w;
  logic                  rneg_r;

  assign mag_w = delta_r[DW-1] ? (~delta_r + DW'(1)) : delta_r;

  // Restoring division of 2^(2*FRAC_BITS): the dividend's only set bit enters first.
  assign trial   = {rem_r, (cnt_r == CW'(QW))};
  assign take    = trial >= {1'b0, div_r};
  assign rem_nxt = take ? DW'(trial - {1'b0, div_r}) : DW'(trial);

  assign cap_w = rneg_r ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (go) begin
      state_r <= ST_DIFF;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          state_r <= ST_IDLE;
        end
        ST_DIFF: begin
          delta_r <= DW'(end_pt) - DW'(start_pt);
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          // zero delta counts as one LSB
          div_r   <= (delta_r == '0) ? DW'(1) : mag_w;
          rneg_r  <= delta_r[DW-1];
          rem_r   <= '0;
          cnt_r   <= CW'(QW);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[QW-2:0], take};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT: begin
          rmag_r  <= (QX'(quo_r) > QX'(cap_w)) ? cap_w : COORD_BITS'(quo_r);
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign rmag = rmag_r;
  assign rneg = rneg_r;
endmodule

// ===== rtl/core/sboi_lane.sv =====
module sboi_lane #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sboi_pkg::sboi_pipe_en_t       pen,
  input  logic                          go,
  input  logic signed [COORD_BITS-1:0]  start_pt,
  input  logic signed [COORD_BITS-1:0]  end_pt,
  input  logic signed [COORD_BITS-1:0]  bmin,
  input  logic signed [COORD_BITS-1:0]  bmax,
  input  logic        [COORD_BITS-2:0]  half,
  output logic                          busy,
  output logic signed [COORD_BITS-1:0]  t_lo,
  output logic signed [COORD_BITS-1:0]  t_hi
);
  import sboi_pkg::*;

  localparam int EW  = COORD_BITS + 2;
  localparam int MW  = COORD_BITS + 1;
  localparam int LB  = (MW + 1) / 2;
  localparam int HB  = MW - LB;
  localparam int LPW = LB + COORD_BITS;
  localparam int HPW = HB + COORD_BITS;
  localparam int PW  = MW + COORD_BITS;
  localparam int SW  = PW - FRAC_BITS;
  localparam int XW  = (SW > COORD_BITS) ? SW : COORD_BITS;

  logic [COORD_BITS-1:0] rmag;
  logic                  rneg;

  logic [EW-1:0]  da_r, db_r;
  logic [MW-1:0]  ma_r, mb_r;
  logic           sa2_r, sb2_r, sa3_r, sb3_r, sa4_r, sb4_r;
  logic [LPW-1:0] pa_lo_r, pb_lo_r;
  logic [HPW-1:0] pa_hi_r, pb_hi_r;
  logic [PW-1:0]  prod_a, prod_b;
  logic [SW-1:0]  sh_a, sh_b;
  logic [COORD_BITS-1:0] cap_a, cap_b, mag_a_r, mag_b_r;
  logic signed [COORD_BITS-1:0] va_r, vb_r, lo_r, hi_r;

  sboi_recip #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .start_pt (start_pt),
    .end_pt   (end_pt),
    .busy     (busy),
    .rmag     (rmag),
    .rneg     (rneg)
  );

  assign prod_a = (PW'(pa_hi_r) << LB) + PW'(pa_lo_r);
  assign prod_b = (PW'(pb_hi_r) << LB) + PW'(pb_lo_r);
  assign sh_a   = prod_a[PW-1:FRAC_BITS];
  assign sh_b   = prod_b[PW-1:FRAC_BITS];
  // the cap follows the sign of the word sitting in the product stage
  assign cap_a  = sa3_r ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
  assign cap_b  = sb3_r ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};

  always_ff @(posedge clk) begin
    // grown slab bounds relative to the sweep start
    if (pen.diff) begin
      da_r <= EW'(bmin) - EW'(half) - EW'(start_pt);
      db_r <= EW'(bmax) + EW'(half) - EW'(start_pt);
    end
    if (pen.absv) begin
      ma_r  <= da_r[EW-1] ? MW'(~da_r + EW'(1)) : MW'(da_r);
      mb_r  <= db_r[EW-1] ? MW'(~db_r + EW'(1)) : MW'(db_r);
      sa2_r <= da_r[EW-1] ^ rneg;
      sb2_r <= db_r[EW-1] ^ rneg;
    end
    // split the wide operand into two partial products
    if (pen.pp) begin
      pa_lo_r <= LPW'(ma_r[LB-1:0]) * LPW'(rmag);
      pa_hi_r <= HPW'(ma_r[MW-1:LB]) * HPW'(rmag);
      pb_lo_r <= LPW'(mb_r[LB-1:0]) * LPW'(rmag);
      pb_hi_r <= HPW'(mb_r[MW-1:LB]) * HPW'(rmag);
      sa3_r   <= sa2_r;
      sb3_r   <= sb2_r;
    end
    if (pen.mag) begin
      mag_a_r <= (XW'(sh_a) > XW'(cap_a)) ? cap_a : COORD_BITS'(sh_a);
      mag_b_r <= (XW'(sh_b) > XW'(cap_b)) ? cap_b : COORD_BITS'(sh_b);
      sa4_r   <= sa3_r;
      sb4_r   <= sb3_r;
    end
    if (pen.sgn) begin
      va_r <= sa4_r ? (~mag_a_r + COORD_BITS'(1)) : mag_a_r;
      vb_r <= sb4_r ? (~mag_b_r + COORD_BITS'(1)) : mag_b_r;
    end
    if (pen.ord) begin
      lo_r <= (va_r < vb_r) ? va_r : vb_r;
      hi_r <= (va_r < vb_r) ? vb_r : va_r;
    end
  end

  assign t_lo = lo_r;
  assign t_hi = hi_r;
endmodule

// ===== rtl/core/sboi_merge.sv =====
module sboi_merge #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  sboi_pkg::sboi_pipe_en_t      pen,
  input  logic signed [COORD_BITS-1:0] range_lo,
  input  logic signed [COORD_BITS-1:0] range_hi,
  input  logic signed [COORD_BITS-1:0] t_lo [sboi_pkg::NLANES],
  input  logic signed [COORD_BITS-1:0] t_hi [sboi_pkg::NLANES],
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] t_enter,
  output logic signed [COORD_BITS-1:0] t_exit
);
  import sboi_pkg::*;

  localparam int RD = 6;

  logic signed [COORD_BITS-1:0] rl_r [RD];
  logic signed [COORD_BITS-1:0] rh_r [RD];
  logic signed [COORD_BITS-1:0] e01_r, e2r_r, x01_r, x2r_r;
  logic signed [COORD_BITS-1:0] enter_r, exit_r, enter_o_r, exit_o_r;
  logic                         hit_r;

  always_ff @(posedge clk) begin
    // carry the incoming interval alongside the lanes
    if (pen.diff) begin
      rl_r[0] <= range_lo;
      rh_r[0] <= range_hi;
    end
    if (pen.absv) begin
      rl_r[1] <= rl_r[0];
      rh_r[1] <= rh_r[0];
    end
    if (pen.pp) begin
      rl_r[2] <= rl_r[1];
      rh_r[2] <= rh_r[1];
    end
    if (pen.mag) begin
      rl_r[3] <= rl_r[2];
      rh_r[3] <= rh_r[2];
    end
    if (pen.sgn) begin
      rl_r[4] <= rl_r[3];
      rh_r[4] <= rh_r[3];
    end
    if (pen.ord) begin
      rl_r[5] <= rl_r[4];
      rh_r[5] <= rh_r[4];
    end
    if (pen.pair) begin
      e01_r <= (t_lo[0] > t_lo[1]) ? t_lo[0] : t_lo[1];
      e2r_r <= (t_lo[2] > rl_r[5]) ? t_lo[2] : rl_r[5];
      x01_r <= (t_hi[0] < t_hi[1]) ? t_hi[0] : t_hi[1];
      x2r_r <= (t_hi[2] < rh_r[5]) ? t_hi[2] : rh_r[5];
    end
    if (pen.fin) begin
      enter_r <= (e01_r > e2r_r) ? e01_r : e2r_r;
      exit_r  <= (x01_r < x2r_r) ? x01_r : x2r_r;
    end
    if (pen.outr) begin
      hit_r     <= (enter_r <= exit_r);
      enter_o_r <= enter_r;
      exit_o_r  <= exit_r;
    end
  end

  assign hit     = hit_r;
  assign t_enter = enter_o_r;
  assign t_exit  = exit_o_r;
endmodule

// ===== rtl/core/swept_box_overlap_interval.sv =====
// Channel  Dir  Handshake    Payload
// in_ch    in   valid/ready  box_min/max xyz, half_size xyz, range_lo, range_hi
// out_ch   out  valid/ready  hit, t_enter, t_exit
// cfg_*    in   cfg_we       cfg_index, cfg_wdata (sweep start and end point)
//
// One word per cycle while out_ch takes words and no reciprocal is recomputed;
// the three axis lanes run in lockstep and a two-level max/min tree merges them.
// Reset and every configuration write restart the per-lane reciprocal dividers,
// one quotient bit a cycle; in_ch.ready stays low until they are done.
// A stall on out_ch backs up stage by stage; bubbles in the pipe are squeezed out.
// rst_n is synchronous, active low: stage valids clear, sweep runs 0 to 1.0.
module swept_box_overlap_interval #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sboi_in_if.sink                               in_ch,
  sboi_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [sboi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_wdata
);
  import sboi_pkg::*;

  localparam logic [COORD_BITS-1:0] ONE_Q = COORD_BITS'(1) << FRAC_BITS;

  logic signed [COORD_BITS-1:0] start_r [NLANES];
  logic signed [COORD_BITS-1:0] end_r   [NLANES];
  logic                         recalc_r;
  logic [NLANES-1:0]            lane_busy;
  logic                         busy;

  logic [NSTG-1:0]              v_r;
  logic [NSTG-1:0]              rdy;
  logic                         in_ready;
  logic                         in_fire;
  sboi_pipe_en_t                pen;

  logic signed [COORD_BITS-1:0] bmin_a [NLANES];
  logic signed [COORD_BITS-1:0] bmax_a [NLANES];
  logic        [COORD_BITS-2:0] half_a [NLANES];
  logic signed [COORD_BITS-1:0] t_lo_a [NLANES];
  logic signed [COORD_BITS-1:0] t_hi_a [NLANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLANES; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= ONE_Q;
      end
      recalc_r <= 1'b1;
    end else begin
      recalc_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X: start_r[0] <= cfg_wdata;
          CFG_START_Y: start_r[1] <= cfg_wdata;
          CFG_START_Z: start_r[2] <= cfg_wdata;
          CFG_END_X:   end_r[0]   <= cfg_wdata;
          CFG_END_Y:   end_r[1]   <= cfg_wdata;
          CFG_END_Z:   end_r[2]   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign busy = recalc_r | (|lane_busy);

  // a stage takes a new word when empty or when the next stage takes its word
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] | out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] | rdy[k+1];
    end
  end

  assign in_ready    = rdy[0] & !busy;
  assign in_fire     = in_ch.valid & in_ready;
  assign in_ch.ready = in_ready;

  assign pen = '{diff: rdy[0], absv: rdy[1], pp: rdy[2], mag: rdy[3], sgn: rdy[4],
                 ord: rdy[5], pair: rdy[6], fin: rdy[7], outr: rdy[8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    bmin_a[0] = in_ch.box_min_x;
    bmin_a[1] = in_ch.box_min_y;
    bmin_a[2] = in_ch.box_min_z;
    bmax_a[0] = in_ch.box_max_x;
    bmax_a[1] = in_ch.box_max_y;
    bmax_a[2] = in_ch.box_max_z;
    half_a[0] = in_ch.half_size_x;
    half_a[1] = in_ch.half_size_y;
    half_a[2] = in_ch.half_size_z;
  end

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    sboi_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .pen      (pen),
      .go       (recalc_r),
      .start_pt (start_r[g]),
      .end_pt   (end_r[g]),
      .bmin     (bmin_a[g]),
      .bmax     (bmax_a[g]),
      .half     (half_a[g]),
      .busy     (lane_busy[g]),
      .t_lo     (t_lo_a[g]),
      .t_hi     (t_hi_a[g])
    );
  end

  sboi_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk      (clk),
    .pen      (pen),
    .range_lo (in_ch.range_lo),
    .range_hi (in_ch.range_hi),
    .t_lo     (t_lo_a),
    .t_hi     (t_hi_a),
    .hit      (out_ch.hit),
    .t_enter  (out_ch.t_enter),
    .t_exit   (out_ch.t_exit)
  );

  assign out_ch.valid = v_r[NSTG-1];

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input taken while reciprocals are stale");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_busy == '0) || (lane_busy == '1))
    else $error("reciprocal dividers out of step");

  a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hit == (out_ch.t_enter <= out_ch.t_exit)))
    else $error("hit flag disagrees with output interval");
`endif
endmodule

// ===== test/swept_box_overlap_interval_test.sv =====
`timescale 1ns / 100ps

module swept_box_overlap_interval_test;
  import sboi_pkg::*;

  localparam int CW              = 32;
  localparam int FRAC            = 16;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 180;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 2000;
  localparam int REPORT_MAX      = 10;

  localparam logic signed [CW-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [CW-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [CW-1:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [CW-1:0] Q_QTR  = 32'sh0000_4000;
  localparam logic signed [CW-1:0] Q_3QTR = 32'sh0000_C000;
  localparam logic [CW-2:0]        HALF_MAX = 31'h7FFF_FFFF;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] START_IDX [3] = '{CFG_START_X, CFG_START_Y, CFG_START_Z};
  localparam logic [CFG_IDX_W-1:0] END_IDX   [3] = '{CFG_END_X, CFG_END_Y, CFG_END_Z};

  typedef enum {W_ALONG, W_RAW, W_EDGE} word_mode_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} stall_mode_t;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
    logic        [CW-2:0] half_x;
    logic        [CW-2:0] half_y;
    logic        [CW-2:0] half_z;
    logic signed [CW-1:0] range_lo;
    logic signed [CW-1:0] range_hi;
  } box_word_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_enter;
    logic signed [CW-1:0] t_exit;
  } overlap_t;

  typedef struct packed {
    box_word_t w;
    logic      pinned;
    overlap_t  want;
  } dir_row_t;

  typedef struct packed {
    logic signed [CW-1:0] lo_edge;
    logic signed [CW-1:0] hi_edge;
    logic        [CW-2:0] half;
  } slab_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_wdata;

  sboi_in_if  #(.COORD_BITS(CW)) in_ch ();
  sboi_out_if #(.COORD_BITS(CW)) out_ch ();

  swept_box_overlap_interval #(
    .COORD_BITS(CW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic signed [CW-1:0] sweep_start [3];
  logic signed [CW-1:0] sweep_end   [3];
  overlap_t             pending_overlaps [$];
  dir_row_t             directed_rows [$];
  int                   faults = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;
  bit                   hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // 2^32 / delta toward zero, zero delta taken as +1 LSB, saturated to 32 bits
  function automatic longint recip_q16(longint d);
    logic [63:0] mag;
    logic [63:0] q;
    logic        negr;
    negr = d < 0;
    if (d == 0) d = 1;
    mag = negr ? -d : d;
    q = 64'h1_0000_0000 / mag;
    if (negr && q > 64'h8000_0000) q = 64'h8000_0000;
    if (!negr && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return negr ? -longint'(q) : longint'(q);
  endfunction

  // exact product, shift toward zero, saturate
  function automatic longint scale_q16(longint a, longint b);
    logic [127:0] prod;
    logic [127:0] cap;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic         negr;
    negr = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = ({64'd0, ma} * {64'd0, mb}) >> FRAC;
    cap = negr ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (prod > cap) prod = cap;
    return negr ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic overlap_t predict_overlap(box_word_t w);
    longint   mn [3];
    longint   mx [3];
    longint   hf [3];
    longint   s;
    longint   r;
    longint   a;
    longint   b;
    longint   t_in;
    longint   t_out;
    overlap_t res;
    mn[0] = w.min_x;  mn[1] = w.min_y;  mn[2] = w.min_z;
    mx[0] = w.max_x;  mx[1] = w.max_y;  mx[2] = w.max_z;
    hf[0] = w.half_x; hf[1] = w.half_y; hf[2] = w.half_z;
    t_in  = w.range_lo;
    t_out = w.range_hi;
    for (int ax = 0; ax < 3; ax++) begin
      s = sweep_start[ax];
      r = recip_q16(longint'(sweep_end[ax]) - s);
      a = scale_q16((mn[ax] - hf[ax]) - s, r);
      b = scale_q16((mx[ax] + hf[ax]) - s, r);
      if ((a < b ? a : b) > t_in) t_in = a < b ? a : b;
      if ((a < b ? b : a) < t_out) t_out = a < b ? b : a;
    end
    res.hit     = t_in <= t_out;
    res.t_enter = t_in[CW-1:0];
    res.t_exit  = t_out[CW-1:0];
    return res;
  endfunction

  function automatic logic signed [CW-1:0] pick_edge();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return Q_ONE;
      6: return -Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  // place a slab somewhere along the sweep so that entry and exit land near [0, 1]
  function automatic slab_t along_slab(int ax);
    longint s;
    longint d;
    longint base;
    longint span;
    longint a;
    longint b;
    slab_t  sl;
    s = sweep_start[ax];
    d = longint'(sweep_end[ax]) - s;
    base = s + ((d * (longint'($urandom_range(0, 24)) - 4)) >>> 4);
    span = ((d < 0) ? -d : d) >>> 3;
    span = span + longint'($urandom_range(0, 4096));
    a = base - longint'($urandom) % (span + 1);
    b = base + longint'($urandom) % (span + 1);
    if ($urandom_range(0, 15) == 0) begin
      sl.lo_edge = b[CW-1:0];
      sl.hi_edge = a[CW-1:0];
    end else begin
      sl.lo_edge = a[CW-1:0];
      sl.hi_edge = b[CW-1:0];
    end
    a = longint'($urandom) % (span / 2 + 1);
    sl.half = a[CW-2:0];
    return sl;
  endfunction

  function automatic box_word_t random_word(word_mode_t m);
    box_word_t w;
    slab_t     sx;
    slab_t     sy;
    slab_t     sz;
    case (m)
      W_ALONG: begin
        sx = along_slab(0);
        sy = along_slab(1);
        sz = along_slab(2);
        w.min_x = sx.lo_edge; w.max_x = sx.hi_edge; w.half_x = sx.half;
        w.min_y = sy.lo_edge; w.max_y = sy.hi_edge; w.half_y = sy.half;
        w.min_z = sz.lo_edge; w.max_z = sz.hi_edge; w.half_z = sz.half;
        case ($urandom_range(0, 3))
          0: begin
            w.range_lo = '0;
            w.range_hi = Q_ONE;
          end
          1: begin
            w.range_lo = Q_MIN;
            w.range_hi = Q_MAX;
          end
          2: begin
            w.range_lo = -$signed(CW'($urandom_range(0, 32'h0001_0000)));
            w.range_hi = CW'($urandom_range(0, 32'h0002_0000));
          end
          default: begin
            w.range_lo = $urandom;
            w.range_hi = $urandom;
          end
        endcase
      end
      W_RAW: begin
        w.min_x = $urandom; w.min_y = $urandom; w.min_z = $urandom;
        w.max_x = $urandom; w.max_y = $urandom; w.max_z = $urandom;
        w.half_x = (CW-1)'($urandom);
        w.half_y = (CW-1)'($urandom);
        w.half_z = (CW-1)'($urandom);
        w.range_lo = $urandom;
        w.range_hi = $urandom;
      end
      default: begin
        w.min_x = pick_edge(); w.min_y = pick_edge(); w.min_z = pick_edge();
        w.max_x = pick_edge(); w.max_y = pick_edge(); w.max_z = pick_edge();
        w.half_x = (CW-1)'(pick_edge());
        w.half_y = (CW-1)'(pick_edge());
        w.half_z = (CW-1)'(pick_edge());
        w.range_lo = pick_edge();
        w.range_hi = pick_edge();
      end
    endcase
    return w;
  endfunction

  function automatic box_word_t cube(logic signed [CW-1:0] mn, logic signed [CW-1:0] mx,
                                     logic [CW-2:0] hs, logic signed [CW-1:0] lo,
                                     logic signed [CW-1:0] hi);
    box_word_t w;
    w.min_x = mn; w.min_y = mn; w.min_z = mn;
    w.max_x = mx; w.max_y = mx; w.max_z = mx;
    w.half_x = hs; w.half_y = hs; w.half_z = hs;
    w.range_lo = lo;
    w.range_hi = hi;
    return w;
  endfunction

  function automatic void add_row(box_word_t w, logic pinned, logic hit,
                                  logic signed [CW-1:0] te, logic signed [CW-1:0] tx);
    dir_row_t row;
    row.w       = w;
    row.pinned  = pinned;
    row.want    = {hit, te, tx};
    directed_rows.push_back(row);
  endfunction

  task automatic put_word(box_word_t w);
    in_ch.box_min_x   <= w.min_x;
    in_ch.box_min_y   <= w.min_y;
    in_ch.box_min_z   <= w.min_z;
    in_ch.box_max_x   <= w.max_x;
    in_ch.box_max_y   <= w.max_y;
    in_ch.box_max_z   <= w.max_z;
    in_ch.half_size_x <= w.half_x;
    in_ch.half_size_y <= w.half_y;
    in_ch.half_size_z <= w.half_z;
    in_ch.range_lo    <= w.range_lo;
    in_ch.range_hi    <= w.range_hi;
  endtask

  task automatic send_word(box_word_t w, logic pinned, overlap_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    put_word(w);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_overlaps.push_back(pinned ? want : predict_overlap(w));
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_overlaps.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_START_X: sweep_start[0] = data;
      CFG_START_Y: sweep_start[1] = data;
      CFG_START_Z: sweep_start[2] = data;
      CFG_END_X:   sweep_end[0]   = data;
      CFG_END_Y:   sweep_end[1]   = data;
      CFG_END_Z:   sweep_end[2]   = data;
      default: ;
    endcase
  endtask

  task automatic program_sweep(int phase);
    longint s;
    longint e;
    longint dir;
    for (int ax = 0; ax < 3; ax++) begin
      dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
      case (phase)
        1: begin
          s = Q_MIN;
          e = Q_MAX;
        end
        2: begin
          s = longint'($signed($urandom));
          e = s;
        end
        3: begin
          s = longint'($signed($urandom));
          e = s - 1;
        end
        4: begin
          s = Q_MAX;
          e = Q_MIN;
        end
        default: begin
          s = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
          case ($urandom_range(0, 3))
            0: e = s + dir * longint'($urandom_range(1, 32'h0004_0000));
            1: begin
              s = longint'($signed($urandom));
              e = longint'($signed($urandom));
            end
            2: e = s + dir * Q_ONE;
            default: e = s + dir;
          endcase
        end
      endcase
      cfg_write(START_IDX[ax], s[CW-1:0]);
      cfg_write(END_IDX[ax], e[CW-1:0]);
    end
    cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin
    box_word_t  w;
    int         pick;
    word_mode_t m;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_START_X;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    put_word('0);
    for (int ax = 0; ax < 3; ax++) begin
      sweep_start[ax] = '0;
      sweep_end[ax]   = Q_ONE;
    end

    // default sweep runs 0 to 1.0 on every axis, so t equals the coordinate
    add_row(cube(Q_QTR, Q_3QTR, '0, '0, Q_ONE), 1'b1, 1'b1, Q_QTR, Q_3QTR);
    add_row(cube(Q_MIN, Q_MAX, HALF_MAX, Q_MIN, Q_MAX), 1'b1, 1'b1, Q_MIN, Q_MAX);
    add_row(cube('0, Q_ONE, '0, Q_ONE, '0), 1'b1, 1'b0, Q_ONE, '0);
    add_row(cube(Q_3QTR, Q_QTR, '0, Q_MIN, Q_MAX), 1'b1, 1'b1, Q_QTR, Q_3QTR);
    w = cube('0, Q_ONE, '0, Q_MIN, Q_MAX);
    w.min_x = 2 * Q_ONE;
    w.max_x = 3 * Q_ONE;
    add_row(w, 1'b1, 1'b0, 2 * Q_ONE, Q_ONE);
    add_row(cube(Q_HALF, Q_HALF, Q_QTR[CW-2:0], Q_MIN, Q_MAX), 1'b1, 1'b1, Q_QTR, Q_3QTR);
    add_row(cube(Q_HALF, Q_HALF, '0, Q_MIN, Q_MAX), 1'b1, 1'b1, Q_HALF, Q_HALF);
    add_row(cube(-Q_ONE, -Q_HALF, '0, Q_MIN, Q_MAX), 1'b1, 1'b1, -Q_ONE, -Q_HALF);
    add_row(cube('0, '0, '0, '0, '0), 1'b1, 1'b1, '0, '0);
    add_row(cube(-32'sd1, -32'sd1, '0, -32'sd1, -32'sd1), 1'b1, 1'b1, -32'sd1, -32'sd1);
    add_row(cube(Q_MIN, Q_MIN, HALF_MAX, '0, Q_ONE), 1'b0, 1'b0, '0, '0);
    add_row(cube(Q_MAX, Q_MAX, HALF_MAX, Q_MIN, Q_MAX), 1'b0, 1'b0, '0, '0);
    add_row(cube(Q_MIN, Q_MAX, '0, Q_MAX, Q_MIN), 1'b0, 1'b0, '0, '0);
    for (int k = 0; k < 3; k++) add_row(random_word(W_RAW), 1'b0, 1'b0, '0, '0);
    for (int k = 0; k < 2; k++) add_row(random_word(W_EDGE), 1'b0, 1'b0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].pinned, directed_rows[i].want);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) program_sweep(ph);
      if (ph == 2 || ph == 6) hold_req = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 19);
        m = (pick < 11) ? W_ALONG : (pick < 16) ? W_RAW : W_EDGE;
        send_word(random_word(m), 1'b0, '0);
      end
      drain();
    end

    repeat (NSTG + 4) @(posedge clk);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    stall_mode_t rx_mode;
    int          rx_left;
    rx_mode = RX_OPEN;
    rx_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the pipe to fill and push back on the input
        repeat (HOLD_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = stall_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    overlap_t got;
    overlap_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.hit, out_ch.t_enter, out_ch.t_exit};
      if (pending_overlaps.size() == 0) begin
        if (faults < REPORT_MAX)
          $display("ERROR: word with nothing pending: hit=%0b enter=%0d exit=%0d",
                   got.hit, $signed(got.t_enter), $signed(got.t_exit));
        faults++;
      end else begin
        want = pending_overlaps.pop_front();
        if (got.hit !== want.hit || got.t_enter !== want.t_enter ||
            got.t_exit !== want.t_exit) begin
          if (faults < REPORT_MAX)
            $display("ERROR: expected hit=%0b enter=%0d exit=%0d, got hit=%0b enter=%0d exit=%0d",
                     want.hit, $signed(want.t_enter), $signed(want.t_exit),
                     got.hit, $signed(got.t_enter), $signed(got.t_exit));
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
